@@ sv/exi_varint_integer_decoder_macros.svh @@
// Assertion helpers for the varint decoder.
`ifndef EXI_VARINT_INTEGER_DECODER_MACROS_SVH
`define EXI_VARINT_INTEGER_DECODER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define EVID_ASSERT_SAME(label, clk, rst_n, ant, con) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error("evid assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define EVID_ASSERT_NEXT(label, clk, rst_n, ant, con) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error("evid assertion failed");

`endif

@@ sv/evid_pkg.sv @@
`timescale 1ns / 1ps
package evid_pkg;

    localparam int VALUE_BITS     = 64;
    localparam int BITS_PER_OCTET = 7;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
    localparam int MORE_BIT       = 7;
    // Octet slots that still land inside 64 bits (shift 0 .. 63).
    localparam logic [3:0] SHIFT_STEPS = 4'd10;
    localparam logic [3:0] COUNT_MAX   = 4'd15;

    typedef enum logic [1:0] {
        WIDTH_16 = 2'd0,
        WIDTH_32 = 2'd1,
        WIDTH_64 = 2'd2
    } t_width_code;

    typedef struct packed {
        logic [7:0] octet;
        logic       signed_mode;
        logic       sign_negative;
    } t_in_beat;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [3:0]            octet_count;
    } t_out_beat;

    // Finished number handed to the result formatter.
    typedef struct packed {
        logic [VALUE_BITS-1:0] acc;
        logic                  is_signed;
        logic                  is_negative;
        logic [3:0]            count;
    } t_fmt_req;

endpackage

@@ sv/evid_in_if.sv @@
`timescale 1ns / 1ps
interface evid_in_if import evid_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/evid_out_if.sv @@
`timescale 1ns / 1ps
interface evid_out_if import evid_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/evid_result_fmt.sv @@
`timescale 1ns / 1ps
module evid_result_fmt import evid_pkg::*; (
    input  t_fmt_req   i_req,
    input  logic [1:0] i_width,
    output t_out_beat  o_beat
);

    logic [15:0]           v16;
    logic [31:0]           v32;
    logic [VALUE_BITS-1:0] value;

    // Negative numbers are the complement of the magnitude within the width.
    always_comb begin
        v16   = i_req.acc[15:0] ^ {16{i_req.is_negative}};
        v32   = i_req.acc[31:0] ^ {32{i_req.is_negative}};
        value = i_req.acc ^ {VALUE_BITS{i_req.is_negative}};
        case (i_width)
            WIDTH_16: begin
                value = i_req.is_signed ? {{(VALUE_BITS-16){v16[15]}}, v16}
                                        : {{(VALUE_BITS-16){1'b0}}, v16};
            end
            WIDTH_32: begin
                value = i_req.is_signed ? {{(VALUE_BITS-32){v32[31]}}, v32}
                                        : {{(VALUE_BITS-32){1'b0}}, v32};
            end
            default: begin
                // 64 bits, and the unused code 3 as well
                value = i_req.acc ^ {VALUE_BITS{i_req.is_negative}};
            end
        endcase
    end

    assign o_beat.value       = value;
    assign o_beat.octet_count = i_req.count;

endmodule

@@ sv/exi_varint_integer_decoder.sv @@
`timescale 1ns / 1ps
// EXI variable-length integer decoder. Feed one octet per beat on i_in; bit 7
// set means more octets follow, and the octet with bit 7 clear closes the
// number and produces one beat on o_out carrying the value (cut to the width
// in i_cfg_wr_data: 0 = 16, 1 = 32, 2 or 3 = 64 bits, then sign-extended in
// signed mode, zero-extended otherwise) and the octet count, saturating at 15.
// signed_mode and sign_negative are sampled on the first octet of a number;
// a negative number comes out as -(magnitude + 1), wrapping within the width.
// Payload bits beyond bit 63 are dropped silently. Throughput is one octet per
// clock unless o_out stalls; a number's last octet goes through the input
// register, then the result register, to o_out. When o_out is stalled with a
// result held, the input keeps flowing until a second closing octet reaches
// the input register; i_in.ready follows o_out.ready combinationally in that
// case. Write the width only while no number is in flight.
`include "exi_varint_integer_decoder_macros.svh"
module exi_varint_integer_decoder import evid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    evid_in_if.sink    i_in,
    evid_out_if.source o_out
);

    // Input register
    logic                  r_s1_valid;
    t_in_beat              r_s1;

    // Number in progress
    logic                  r_in_number;
    logic [VALUE_BITS-1:0] r_acc;
    logic [3:0]            r_k;        // octet slot, shift = 7 * r_k
    logic [3:0]            r_cnt;
    logic                  r_signed;
    logic                  r_neg;

    logic [1:0]            r_value_width;

    // Result register
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic                  s1_last;
    logic                  out_free;
    logic                  s1_adv;
    logic                  in_fire;

    logic [VALUE_BITS-1:0] acc_base;
    logic [3:0]            k_base;
    logic [3:0]            cnt_base;
    logic                  sgn_eff;
    logic                  neg_eff;
    logic [5:0]            shamt;
    logic [6:0]            payload;
    logic [VALUE_BITS-1:0] n_acc;
    logic [3:0]            n_k;
    logic [3:0]            n_cnt;
    t_fmt_req              fmt_req;
    t_out_beat             fmt_beat;

    // Handshake: the input register moves on unless it holds a closing
    // octet and the result register is still occupied.
    assign s1_last  = r_s1_valid && !r_s1.octet[MORE_BIT];
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && (!s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire  = i_in.valid && i_in.ready;

    // Start a fresh number from zero when none is in progress.
    always_comb begin
        acc_base = r_in_number ? r_acc : '0;
        k_base   = r_in_number ? r_k : '0;
        cnt_base = r_in_number ? r_cnt : '0;
        sgn_eff  = r_in_number ? r_signed : r_s1.signed_mode;
        neg_eff  = r_in_number ? r_neg : (r_s1.signed_mode && r_s1.sign_negative);
        payload  = 7'(r_s1.octet & PAYLOAD_MASK);
        shamt    = 6'(k_base * BITS_PER_OCTET);
        n_acc    = acc_base;
        n_k      = k_base;
        if (k_base < SHIFT_STEPS) begin
            // Slots do not overlap, so OR is the add.
            n_acc = acc_base | (VALUE_BITS'(payload) << shamt);
            n_k   = k_base + 4'd1;
        end
        n_cnt = (cnt_base < COUNT_MAX) ? cnt_base + 4'd1 : cnt_base;
    end

    assign fmt_req.acc         = n_acc;
    assign fmt_req.is_signed   = sgn_eff;
    assign fmt_req.is_negative = neg_eff;
    assign fmt_req.count       = n_cnt;

    evid_result_fmt u_fmt (
        .i_req   (fmt_req),
        .i_width (r_value_width),
        .o_beat  (fmt_beat)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_width <= WIDTH_64;
        end else if (i_cfg_wr_en) begin
            r_value_width <= i_cfg_wr_data;
        end
    end

    // Input register: load on accept, drop when it advances empty-handed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in.data;
        end
    end

    // Number state: advance on a continuation octet, clear on the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_acc       <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_signed    <= 1'b0;
            r_neg       <= 1'b0;
        end else if (s1_adv) begin
            if (s1_last) begin
                r_in_number <= 1'b0;
                r_acc       <= '0;
                r_k         <= '0;
                r_cnt       <= '0;
                r_signed    <= 1'b0;
                r_neg       <= 1'b0;
            end else begin
                r_in_number <= 1'b1;
                r_acc       <= n_acc;
                r_k         <= n_k;
                r_cnt       <= n_cnt;
                r_signed    <= sgn_eff;
                r_neg       <= neg_eff;
            end
        end
    end

    // Result register: load the finished number, hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_last) begin
            r_out <= fmt_beat;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `EVID_ASSERT_SAME(a_progress_counts, i_clk, i_rst_n, r_in_number, (r_k != 4'd0) && (r_cnt != 4'd0))
    `EVID_ASSERT_SAME(a_slot_bound, i_clk, i_rst_n, 1'b1, r_k <= SHIFT_STEPS)
    `EVID_ASSERT_NEXT(a_last_loads_out, i_clk, i_rst_n, s1_adv && s1_last, r_out_valid && !r_in_number)
    `EVID_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_out.ready, !(s1_adv && s1_last))

endmodule

@@ test/exi_varint_integer_decoder_tb.sv @@
`timescale 1ns / 1ps
module exi_varint_integer_decoder_tb;
    import evid_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 4;
    // Two register stages between the last octet and its result; pad generously.
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_HOLDS      = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_OCTETS   = 85;
    localparam int MAX_GAP        = 15;
    // Width code three is not in the enum; the block treats it as 64 bits.
    localparam logic [1:0] WIDTH_CODE_THREE = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;

    evid_in_if  in_bus ();
    evid_out_if out_bus ();

    exi_varint_integer_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_bus.sink),
        .o_out         (out_bus.source)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Octets waiting to be sent, and decoded numbers waiting to come out.
    t_in_beat  octet_q[$];
    t_out_beat decoded_q[$];

    // Shadow of the width register and of the decoder state.
    logic [1:0]  width_sel = WIDTH_64;
    logic [63:0] acc;
    int unsigned acc_shift;
    logic [3:0]  octets;
    bit          num_open;
    bit          num_signed;
    bit          num_negative;

    // Idling switches, set per phase.
    bit send_idle;
    bit take_idle;

    int mismatch_count = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;

    // Fold one accepted octet into the shadow state; on a closing octet,
    // format the number at the current width and queue it.
    function automatic void decode_octet(input t_in_beat beat);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] v;
        t_out_beat   res;
        if (!num_open) begin
            num_open     = 1'b1;
            acc          = '0;
            acc_shift    = 0;
            octets       = '0;
            num_signed   = beat.signed_mode;
            num_negative = beat.signed_mode && beat.sign_negative;
        end
        // Past bit 63 the payload is dropped and the shift stops growing.
        if (acc_shift < VALUE_BITS) begin
            acc       = acc + (64'(beat.octet & PAYLOAD_MASK) << acc_shift);
            acc_shift = acc_shift + BITS_PER_OCTET;
        end
        if (octets != COUNT_MAX) octets = octets + 4'd1;
        if (beat.octet[MORE_BIT]) return;

        case (width_sel)
            WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
            WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
            default:  mask = '1;
        endcase
        mag = acc & mask;
        // Negative: complement of the magnitude within the width, so it wraps.
        v = num_negative ? (~mag & mask) : mag;
        if (num_signed && mask != '1 && (v & (mask ^ (mask >> 1))) != '0) v = v | ~mask;

        res.value       = v;
        res.octet_count = octets;
        decoded_q.push_back(res);
        num_open = 1'b0;
    endfunction

    // Compare one result beat with the oldest decoded number.
    function automatic void check_result(input t_out_beat got);
        t_out_beat want;
        results_seen++;
        if (decoded_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: value %h count %0d",
                         got.value, got.octet_count);
        end else begin
            want = decoded_q.pop_front();
            if (got.value !== want.value || got.octet_count !== want.octet_count) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: value exp %h got %h, count exp %0d got %0d",
                             want.value, got.value, want.octet_count, got.octet_count);
            end
        end
    endfunction

    // Sender: present the next octet once its drawn gap has run out; hold the
    // beat while ready is low.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                decode_octet(in_bus.data);
                send_gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
            end else if (!in_bus.valid && send_gap > 0) begin
                send_gap--;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (send_gap == 0 && octet_q.size() > 0) begin
                    in_bus.valid <= 1'b1;
                    in_bus.data  <= octet_q.pop_front();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat, then stall a drawn number of cycles.
    // A couple of times, with plenty of octets still queued, hold ready low
    // for a long stretch so the decoder backs up and stalls its input.
    int take_stall = 0;
    int hold_left  = 0;
    int holds_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            take_stall = 0;
            hold_left  = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                check_result(out_bus.data);
                take_stall = take_idle ? $urandom_range(0, MAX_GAP) : 0;
            end else if (take_stall > 0) begin
                take_stall--;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_done < MAX_HOLDS && octet_q.size() > 40 &&
                         results_seen >= 10 + holds_done * 50) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            out_bus.ready <= (take_stall == 0 && hold_left == 0);
        end
    end

    // Watchdog: end the run when neither side has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("exi_varint_integer_decoder regression: fail");
            $finish;
        end
    end

    task automatic queue_octet(input logic [7:0] oct, input bit sgn, input bit neg);
        t_in_beat beat;
        beat.octet         = oct;
        beat.signed_mode   = sgn;
        beat.sign_negative = neg;
        octet_q.push_back(beat);
    endtask

    // Queue one well-formed number; sign bits on later octets are random
    // since only the first octet's are sampled.
    task automatic queue_number(input int len, input bit sgn, input bit neg);
        logic [6:0] payload;
        logic [7:0] oct;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
                0:       payload = 7'h00;
                1:       payload = 7'h7F;
                default: payload = 7'($urandom);
            endcase
            oct = {1'b0, payload};
            oct[MORE_BIT] = (i != len - 1);
            if (i == 0) queue_octet(oct, sgn, neg);
            else queue_octet(oct, 1'($urandom), 1'($urandom));
        end
    endtask

    // Mostly short numbers, some mid-length, a few long enough to run past
    // bit 63, some also saturating the count; about one in ten draws is raw noise.
    // Always leave the stream closed so the next width write finds it idle.
    task automatic queue_random(input int count);
        int         added;
        int         len;
        int         r;
        bit         open;
        logic [7:0] oct;
        added = 0;
        open  = 1'b0;
        while (added < count || open) begin
            r = $urandom_range(0, 19);
            if (r < 2) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    oct = 8'($urandom);
                    queue_octet(oct, 1'($urandom), 1'($urandom));
                    open = oct[MORE_BIT];
                end
            end else begin
                if (r < 12)      len = $urandom_range(1, 3);
                else if (r < 17) len = $urandom_range(4, 10);
                else             len = $urandom_range(11, 20);
                queue_number(len, 1'($urandom), 1'($urandom));
                open = 1'b0;
            end
            added += len;
        end
    endtask

    // Block until every octet is taken and every decoded number has come out.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (octet_q.size() != 0 || in_bus.valid || decoded_q.size() != 0);
    endtask

    // Write the width only with nothing in flight, then track it in the shadow.
    task automatic write_width(input logic [1:0] code);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= code;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        width_sel = code;
    endtask

    logic [1:0] phase_width[5] = '{WIDTH_16, WIDTH_32, WIDTH_CODE_THREE, WIDTH_64, WIDTH_16};

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = WIDTH_64;
        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        out_bus.ready = 1'b0;
        num_open      = 1'b0;
        send_idle     = 1'b1;
        take_idle     = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset width of 64 bits.
        queue_octet(8'h00, 1'b0, 1'b0);           // zero
        queue_octet(8'h7F, 1'b0, 1'b0);           // largest single octet
        queue_octet(8'h05, 1'b0, 1'b1);           // sign ignored in unsigned mode
        queue_octet(8'h00, 1'b1, 1'b1);           // signed negative zero gives -1
        // Sixteen octets: payload past bit 63 dropped, count saturates.
        repeat (15) queue_octet(8'hFF, 1'b0, 1'b0);
        queue_octet(8'h7F, 1'b0, 1'b0);

        for (int p = 0; p < 5; p++) begin
            write_width(phase_width[p]);
            // Leave one phase with no idling on either side, one sender-only.
            send_idle = (p != 1);
            take_idle = (p != 1 && p != 3);
            if (p == 0) begin
                // 16-bit magnitude 0xFFFF, negative: wraps to zero.
                queue_octet(8'hFF, 1'b1, 1'b1);
                queue_octet(8'hFF, 1'b0, 1'b0);
                queue_octet(8'h03, 1'b0, 1'b0);
                // 0x8000 positive in signed mode: top bit sign-extends.
                queue_octet(8'h80, 1'b1, 1'b0);
                queue_octet(8'h80, 1'b0, 1'b1);
                queue_octet(8'h02, 1'b0, 1'b1);
            end
            queue_random(PHASE_OCTETS);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && decoded_q.size() == 0) begin
            $display("exi_varint_integer_decoder regression: pass");
        end else begin
            $display("exi_varint_integer_decoder regression: fail");
        end
        $finish;
    end

endmodule
